// ----- rtl/pfsr_pkg.sv -----
package pfsr_pkg;

  // Field widths of a request and of a result.
  localparam int PID_W        = 13;
  localparam int ACT_W        = 2;
  localparam int SLOT_FIELD_W = 4;

  // Default number of filter slots, which is also the longest wanted list.
  localparam int SLOTS_DEF = 16;

  // Result action codes.
  typedef enum logic [ACT_W-1:0] {
    ACT_STOP  = 2'd0,
    ACT_START = 2'd1,
    ACT_SKIP  = 2'd2,
    ACT_DONE  = 2'd3
  } action_t;

endpackage

// ----- rtl/pfsr_ram.sv -----
module pfsr_ram #(
  parameter int W = 13,
  parameter int D = 16,
  localparam int AW = (D > 1) ? $clog2(D) : 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [D];
  logic [W-1:0] rdata_r;

  // One write port and one read port with registered read data.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/pid_filter_slot_reconcile.sv -----
// PID filter slot table. Each request is taken while busy is low and loads one
// entry of the wanted list, unless SLOTS entries are already held; an entry
// without list_end gives no result. A request with list_end loads its entry and
// then reconciles the table: busy stays high while the block first stops every
// held PID that the list no longer names, in slot order, then starts every
// listed PID not yet held in the lowest free slot (or reports it skipped), and
// ends with a done result that carries out_run_last. Results appear on
// out_valid for exactly one cycle each and can not be held off, so the receiver
// must take every strobe. The PIDs live in two single-read-port RAMs and every
// membership search reads the used entries of the other store one at a time,
// each read in ST_SRD and compared in ST_SCMP. No clearing pass is needed
// after reset.
module pid_filter_slot_reconcile #(
  parameter int SLOTS = pfsr_pkg::SLOTS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [pfsr_pkg::PID_W-1:0]          in_pid,
  input  logic                                in_entry_used,
  input  logic                                in_list_end,
  output logic                                out_valid,
  output logic [pfsr_pkg::ACT_W-1:0]          out_action,
  output logic [pfsr_pkg::SLOT_FIELD_W-1:0]   out_slot,
  output logic [pfsr_pkg::PID_W-1:0]          out_pid_out,
  output logic                                out_run_last
);

  import pfsr_pkg::*;

  localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);
  localparam logic [CW-1:0] LAST_CNT = CW'(SLOTS);

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_SEL  = 6'b000010,
    ST_CAP  = 6'b000100,
    ST_SRD  = 6'b001000,
    ST_SCMP = 6'b010000,
    ST_DONE = 6'b100000
  } state_t;

  state_t             state_r, state_nxt;
  logic               phase_r, phase_nxt;          // 0: stop pass, 1: start pass
  logic [CW-1:0]      i_r, i_nxt;                  // outer index
  logic [CW-1:0]      j_r, j_nxt;                  // search index
  logic [PID_W-1:0]   cur_pid_r, cur_pid_nxt;
  logic [SLOTS-1:0]   slot_active_r, slot_active_nxt;
  logic [SLOTS-1:0]   wanted_used_r, wanted_used_nxt;
  logic [CW-1:0]      load_cnt_r, load_cnt_nxt;

  logic               out_valid_r, out_valid_nxt;
  action_t            out_action_r, out_action_nxt;
  logic [SLOT_FIELD_W-1:0] out_slot_r, out_slot_nxt;
  logic [PID_W-1:0]   out_pid_r, out_pid_nxt;
  logic               out_last_r, out_last_nxt;

  logic               slot_we, wanted_we;
  logic [AW-1:0]      slot_waddr, wanted_waddr;
  logic [PID_W-1:0]   slot_wdata;
  logic [AW-1:0]      slot_raddr, wanted_raddr;
  logic [PID_W-1:0]   slot_rdata, wanted_rdata;
  logic [PID_W-1:0]   outer_rdata, inner_rdata;
  logic [SLOTS-1:0]   outer_v, inner_v;

  logic               free_any;
  logic [AW-1:0]      free_idx;
  logic [31:0]        i_wide, free_wide;
  logic               accept;

  // Slot PID store and wanted list store.
  pfsr_ram #(.W(PID_W), .D(SLOTS)) u_slot_ram (
    .clk   (clk),
    .we    (slot_we),
    .waddr (slot_waddr),
    .wdata (slot_wdata),
    .raddr (slot_raddr),
    .rdata (slot_rdata)
  );

  pfsr_ram #(.W(PID_W), .D(SLOTS)) u_wanted_ram (
    .clk   (clk),
    .we    (wanted_we),
    .waddr (wanted_waddr),
    .wdata (in_pid),
    .raddr (wanted_raddr),
    .rdata (wanted_rdata)
  );

  // The outer walk reads one store at i, the search reads the other at j.
  assign slot_raddr   = phase_r ? j_r[AW-1:0] : i_r[AW-1:0];
  assign wanted_raddr = phase_r ? i_r[AW-1:0] : j_r[AW-1:0];
  assign outer_rdata  = phase_r ? wanted_rdata : slot_rdata;
  assign inner_rdata  = phase_r ? slot_rdata : wanted_rdata;
  assign outer_v      = phase_r ? wanted_used_r : slot_active_r;
  assign inner_v      = phase_r ? slot_active_r : wanted_used_r;

  // Lowest free slot.
  always_comb begin
    free_any = 1'b0;
    free_idx = '0;
    for (int k = SLOTS - 1; k >= 0; k--) begin
      if (!slot_active_r[k]) begin
        free_any = 1'b1;
        free_idx = AW'(k);
      end
    end
  end

  assign i_wide    = 32'(i_r);
  assign free_wide = 32'(free_idx);
  assign busy      = (state_r != ST_IDLE);
  assign accept    = start && !busy;

  // Load and reconciliation sequencer.
  always_comb begin
    state_nxt       = state_r;
    phase_nxt       = phase_r;
    i_nxt           = i_r;
    j_nxt           = j_r;
    cur_pid_nxt     = cur_pid_r;
    slot_active_nxt = slot_active_r;
    wanted_used_nxt = wanted_used_r;
    load_cnt_nxt    = load_cnt_r;
    out_valid_nxt   = 1'b0;
    out_action_nxt  = out_action_r;
    out_slot_nxt    = out_slot_r;
    out_pid_nxt     = out_pid_r;
    out_last_nxt    = 1'b0;
    slot_we         = 1'b0;
    slot_waddr      = free_idx;
    slot_wdata      = cur_pid_r;
    wanted_we       = 1'b0;
    wanted_waddr    = load_cnt_r[AW-1:0];

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (load_cnt_r != LAST_CNT) begin
            wanted_we = 1'b1;
            wanted_used_nxt[load_cnt_r[AW-1:0]] = in_entry_used;
            load_cnt_nxt = load_cnt_r + CW'(1);
          end
          if (in_list_end) begin
            phase_nxt = 1'b0;
            i_nxt     = '0;
            state_nxt = ST_SEL;
          end
        end
      end

      // Pick the next active slot (stop pass) or used entry (start pass).
      ST_SEL: begin
        if (i_r == LAST_CNT) begin
          i_nxt = '0;
          if (!phase_r) begin
            phase_nxt = 1'b1;
          end else begin
            state_nxt = ST_DONE;
          end
        end else if (!outer_v[i_r[AW-1:0]]) begin
          i_nxt = i_r + CW'(1);
        end else begin
          state_nxt = ST_CAP;
        end
      end

      ST_CAP: begin
        cur_pid_nxt = outer_rdata;
        j_nxt       = '0;
        state_nxt   = ST_SRD;
      end

      // Search the other store; reaching the end means the PID was not found.
      ST_SRD: begin
        if (j_r == LAST_CNT) begin
          out_valid_nxt = 1'b1;
          out_pid_nxt   = cur_pid_r;
          if (!phase_r) begin
            out_action_nxt = ACT_STOP;
            out_slot_nxt   = i_wide[SLOT_FIELD_W-1:0];
            slot_active_nxt[i_r[AW-1:0]] = 1'b0;
          end else if (free_any) begin
            out_action_nxt = ACT_START;
            out_slot_nxt   = free_wide[SLOT_FIELD_W-1:0];
            slot_we        = 1'b1;
            slot_active_nxt[free_idx] = 1'b1;
          end else begin
            out_action_nxt = ACT_SKIP;
            out_slot_nxt   = '0;
          end
          i_nxt     = i_r + CW'(1);
          state_nxt = ST_SEL;
        end else if (!inner_v[j_r[AW-1:0]]) begin
          j_nxt = j_r + CW'(1);
        end else begin
          state_nxt = ST_SCMP;
        end
      end

      // A match ends the search with no result for this index.
      ST_SCMP: begin
        if (inner_rdata == cur_pid_r) begin
          i_nxt     = i_r + CW'(1);
          state_nxt = ST_SEL;
        end else begin
          j_nxt     = j_r + CW'(1);
          state_nxt = ST_SRD;
        end
      end

      ST_DONE: begin
        out_valid_nxt   = 1'b1;
        out_action_nxt  = ACT_DONE;
        out_slot_nxt    = '0;
        out_pid_nxt     = '0;
        out_last_nxt    = 1'b1;
        wanted_used_nxt = '0;
        load_cnt_nxt    = '0;
        phase_nxt       = 1'b0;
        state_nxt       = ST_IDLE;
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control state is reset; payload registers are not.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      phase_r       <= 1'b0;
      slot_active_r <= '0;
      wanted_used_r <= '0;
      load_cnt_r    <= '0;
      out_valid_r   <= 1'b0;
      out_last_r    <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      phase_r       <= phase_nxt;
      slot_active_r <= slot_active_nxt;
      wanted_used_r <= wanted_used_nxt;
      load_cnt_r    <= load_cnt_nxt;
      out_valid_r   <= out_valid_nxt;
      out_last_r    <= out_last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    i_r          <= i_nxt;
    j_r          <= j_nxt;
    cur_pid_r    <= cur_pid_nxt;
    out_action_r <= out_action_nxt;
    out_slot_r   <= out_slot_nxt;
    out_pid_r    <= out_pid_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_action   = out_action_r;
  assign out_slot     = out_slot_r;
  assign out_pid_out  = out_pid_r;
  assign out_run_last = out_last_r;

  // Results only come out of a reconciliation run.
  a_result_from_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result strobe without a reconciliation run");

  // The done result closes the run and frees the block at once.
  a_done_frees: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_run_last) |-> (!busy && load_cnt_r == '0))
    else $error("block still busy after the done result");

  // Only the done result carries the run end mark.
  a_last_is_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_run_last == (out_action == ACT_DONE)))
    else $error("run end mark disagrees with the action");

  // The load position never passes the list length.
  a_load_bound: assert property (@(posedge clk) disable iff (!rst_n)
    load_cnt_r <= LAST_CNT)
    else $error("load position beyond the list length");

endmodule
